>>> rtl/sdft_pkg.sv
// Shared constants, types and elaboration-time table math for the sliding-window
// single-bin DFT magnitude block. No dependencies.
`default_nettype none

package sdft_pkg;

   localparam int SAMPLE_W = 16;
   localparam int PHASE_W  = 32;
   localparam int MAG_W    = 28;
   localparam int WLEN_W   = 13;
   localparam int Q_W      = 15;
   localparam int PROD_W   = 32;
   localparam int CH_W     = 16;
   localparam int SQ_SHIFT = 30;

   localparam logic [WLEN_W-1:0] WLEN_RESET = 13'd4096;
   localparam logic [63:0]       PI_Q61     = 64'h6487_ED51_10B4_611A;
   localparam logic [63:0]       MAG_MAX    = 64'h0FFF_FFFF;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef struct packed {
      logic           neg;
      logic [Q_W-1:0] mag;
   } sdft_trig_type;

   // Q61 product, truncated to 64 bits
   function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[124:61];
   endfunction

   // shift-subtract long division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      r = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r    = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // round(32768 * sin(2*pi*k / 2^bits)) for 0 < k < 2^bits / 4, Taylor series in Q61
   function automatic logic [Q_W-1:0] quarter_sine(input int unsigned k,
                                                   input int unsigned bits);
      logic [127:0] p;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      p    = {64'd0, PI_Q61} * {96'd0, 32'(k)};
      x    = 64'(p >> (bits - 1));
      x2   = mul_q61(x, x);
      term = x;
      sum  = x;
      for (int unsigned n = 1; n <= 14; n++) begin
         term = udiv64(mul_q61(term, x2), 64'((2 * n) * (2 * n + 1)));
         if (n[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      sum = (sum + (64'd1 << 45)) >> 46;
      if (sum > 64'd32767) begin
         sum = 64'd32767;
      end
      return Q_W'(sum);
   endfunction

endpackage

`default_nettype wire

>>> rtl/sdft_if.sv
// Valid/ready channel interfaces: request, response and window-length write.
// Depends on sdft_pkg.
`default_nettype none

interface sdft_req_if import sdft_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [SAMPLE_W-1:0] sample;
   logic [PHASE_W-1:0]  phase_step;

   modport source (output valid, output command, output sample, output phase_step,
                   input ready);
   modport sink   (input valid, input command, input sample, input phase_step,
                   output ready);
endinterface

interface sdft_rsp_if import sdft_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude;

   modport source (output valid, output magnitude, input ready);
   modport sink   (input valid, input magnitude, output ready);
endinterface

interface sdft_csr_if import sdft_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WLEN_W-1:0] window_length;

   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);
endinterface

`default_nettype wire

>>> rtl/sliding_window_dft_bin_magnitude.sv
// Sliding-window single-bin DFT magnitude, top level.
// Depends on sdft_pkg, sdft_if, sdft_ram, sdft_sine_rom, sdft_mag.
//
// Channels: req carries push (command 0, shifts one sample into the window) or
// evaluate (command 1, correlates the newest window_length samples against the
// bin given by phase_step). rsp returns one magnitude per evaluate; pushes give
// none. csr writes window_length and is always ready; write it only while idle.
//
// Pushes may follow back to back. An evaluate reads
// every window sample once through the single read port of the sample RAM: a
// setup state, one read per window sample and a pipeline drain, then chunked
// squaring and a one-bit-per-cycle square root, and a load of the rsp register.
// req.ready is low from the time the evaluate is taken until its result is loaded.
// One item is in flight at a time.
//
// After reset the sample RAM is swept to zero, with req.ready low, and window_length
// returns to 4096. A result waits in the rsp register while the receiver stalls;
// pushes are still taken, and a following evaluate holds its result until the
// register drains.
`default_nettype none

module sliding_window_dft_bin_magnitude import sdft_pkg::*; #(
   parameter int WINDOW_MAX      = 4096,
   parameter int SINE_TABLE_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   sdft_req_if.sink   req,
   sdft_rsp_if.source rsp,
   sdft_csr_if.sink   csr
);

   localparam int PTR_W = $clog2(WINDOW_MAX);
   localparam int PS_W  = $clog2(2 * WINDOW_MAX);
   localparam int LEN_W = ($clog2(WINDOW_MAX + 1) > WLEN_W) ? $clog2(WINDOW_MAX + 1) : WLEN_W;
   localparam int ACC_W = 31 + $clog2(WINDOW_MAX);
   localparam int TB    = SINE_TABLE_BITS;
   localparam logic [TB-1:0] QUARTER_TURN = TB'(2 ** (TB - 2));

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_SETUP, ST_CORR, ST_DRAIN, ST_MAG, ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic [PTR_W-1:0]         wp_ff, wp_in;
   logic [WLEN_W-1:0]        wlen_ff, wlen_in;
   logic [PS_W-1:0]          pos_ff, pos_in;
   logic [LEN_W-1:0]         cnt_ff, cnt_in;
   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic [PHASE_W-1:0]       step_ff, step_in;
   logic                     v1_ff, v1_in;
   logic                     v2_ff, v2_in;
   logic signed [PROD_W-1:0] prod_re_ff, prod_re_in;
   logic signed [PROD_W-1:0] prod_im_ff, prod_im_in;
   logic                     neg_re_ff, neg_re_in;
   logic                     neg_im_ff, neg_im_in;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0]  acc_im_ff, acc_im_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0]         rsp_mag_ff, rsp_mag_in;

   logic                req_accept;
   logic [PTR_W-1:0]    wp_next;
   logic [LEN_W-1:0]    len_eff;
   logic [PS_W-1:0]     pos_start;

   logic                ram_we;
   logic [SAMPLE_W-1:0] ram_wdata;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic [TB-1:0]       idx_sin;
   logic [TB-1:0]       idx_cos;
   sdft_trig_type       trig_sin;
   sdft_trig_type       trig_cos;
   logic                mag_start;
   logic                mag_done;
   logic [MAG_W-1:0]    mag_value;

   assign req.ready  = (state_ff == ST_IDLE);
   assign req_accept = req.valid && req.ready;
   assign csr.ready  = 1'b1;

   assign wp_next   = (wp_ff == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_ff + 1'b1;
   assign len_eff   = (LEN_W'(wlen_ff) > LEN_W'(WINDOW_MAX)) ? LEN_W'(WINDOW_MAX)
                                                             : LEN_W'(wlen_ff);
   assign pos_start = PS_W'(wp_ff) + PS_W'(WINDOW_MAX) - PS_W'(len_eff);

   assign ram_we    = (state_ff == ST_CLEAR) || (req_accept && req.command == CMD_PUSH);
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : req.sample;

   assign idx_sin = phase_ff[PHASE_W-1 -: TB];
   assign idx_cos = idx_sin + QUARTER_TURN;

   assign mag_start = (state_ff == ST_DRAIN) && !v1_ff && !v2_ff;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      wlen_in      = csr.valid ? csr.window_length : wlen_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mag_in   = rsp_mag_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wp_in = wp_next;
            if (wp_ff == PTR_W'(WINDOW_MAX - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req.command == CMD_PUSH) begin
                  wp_in = wp_next;
               end else begin
                  pos_in   = pos_start;
                  cnt_in   = len_eff;
                  step_in  = req.phase_step;
                  phase_in = '0;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            if (pos_ff >= PS_W'(WINDOW_MAX)) begin
               pos_in = pos_ff - PS_W'(WINDOW_MAX);
            end
            state_in = (cnt_ff == '0) ? ST_DRAIN : ST_CORR;
         end
         ST_CORR: begin
            pos_in   = (pos_ff == PS_W'(WINDOW_MAX - 1)) ? '0 : pos_ff + 1'b1;
            phase_in = phase_ff + step_ff;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == LEN_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mag_start) begin
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            if (mag_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mag_in   = mag_value;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // read -> multiply -> accumulate
   always_comb begin
      v1_in      = (state_ff == ST_CORR);
      v2_in      = v1_ff;
      prod_re_in = PROD_W'($signed(ram_rdata)) * PROD_W'($signed({1'b0, trig_cos.mag}));
      prod_im_in = PROD_W'($signed(ram_rdata)) * PROD_W'($signed({1'b0, trig_sin.mag}));
      neg_re_in  = trig_cos.neg;
      neg_im_in  = trig_sin.neg;
      acc_re_in  = acc_re_ff;
      acc_im_in  = acc_im_ff;
      if (state_ff == ST_SETUP) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (v2_ff) begin
         acc_re_in = neg_re_ff ? acc_re_ff - ACC_W'(prod_re_ff) : acc_re_ff + ACC_W'(prod_re_ff);
         acc_im_in = neg_im_ff ? acc_im_ff - ACC_W'(prod_im_ff) : acc_im_ff + ACC_W'(prod_im_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wp_ff        <= '0;
         wlen_ff      <= WLEN_RESET;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         wlen_ff      <= wlen_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_mag_ff   <= rsp_mag_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      cnt_ff     <= cnt_in;
      phase_ff   <= phase_in;
      step_ff    <= step_in;
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
      neg_re_ff  <= neg_re_in;
      neg_im_ff  <= neg_im_in;
      acc_re_ff  <= acc_re_in;
      acc_im_ff  <= acc_im_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.magnitude = rsp_mag_ff;

   sdft_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_MAX)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (ram_wdata),
      .rd_addr (pos_ff[PTR_W-1:0]),
      .rd_data (ram_rdata)
   );

   sdft_sine_rom #(
      .TABLE_BITS (SINE_TABLE_BITS)
   ) u_sine_rom (
      .clock  (clock),
      .idx_a  (idx_sin),
      .idx_b  (idx_cos),
      .trig_a (trig_sin),
      .trig_b (trig_cos)
   );

   sdft_mag #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_mag (
      .clock     (clock),
      .reset     (reset),
      .start     (mag_start),
      .re        (acc_re_ff),
      .im        (acc_im_ff),
      .done      (mag_done),
      .magnitude (mag_value)
   );

endmodule

`default_nettype wire

>>> rtl/sdft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sdft_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/sdft_sine_rom.sv
// Two-port quarter-wave sine ROM with registered outputs; returns magnitude and sign.
// Depends on sdft_pkg (table math, trig type).
`default_nettype none

module sdft_sine_rom import sdft_pkg::*; #(
   parameter int TABLE_BITS = 12
) (
   input  logic                  clock,
   input  logic [TABLE_BITS-1:0] idx_a,
   input  logic [TABLE_BITS-1:0] idx_b,
   output sdft_trig_type         trig_a,
   output sdft_trig_type         trig_b
);

   localparam int QN   = 2 ** (TABLE_BITS - 2);
   localparam int QA_W = TABLE_BITS - 1;

   typedef logic [Q_W-1:0] quarter_type [QN+1];

   function automatic quarter_type build_quarter();
      quarter_type t;
      for (int k = 0; k <= QN; k++) begin
         if (k == 0) begin
            t[k] = '0;
         end else if (k == QN) begin
            t[k] = Q_W'(32767);
         end else begin
            t[k] = quarter_sine(k, TABLE_BITS);
         end
      end
      return t;
   endfunction

   localparam quarter_type QTAB = build_quarter();

   function automatic logic [QA_W-1:0] fold_addr(input logic [TABLE_BITS-1:0] idx);
      logic [QA_W-1:0] r;
      r = QA_W'(idx[TABLE_BITS-3:0]);
      return idx[TABLE_BITS-2] ? (QA_W'(QN) - r) : r;
   endfunction

   sdft_trig_type trig_a_ff;
   sdft_trig_type trig_b_ff;

   always_ff @(posedge clock) begin
      trig_a_ff.neg <= idx_a[TABLE_BITS-1];
      trig_a_ff.mag <= QTAB[fold_addr(idx_a)];
      trig_b_ff.neg <= idx_b[TABLE_BITS-1];
      trig_b_ff.mag <= QTAB[fold_addr(idx_b)];
   end

   assign trig_a = trig_a_ff;
   assign trig_b = trig_b_ff;

endmodule

`default_nettype wire

>>> rtl/sdft_mag.sv
// Magnitude unit: squares both sums in 16-bit chunks, then a bit-serial integer
// square root of (re^2 + im^2) >> 30, capped. Depends on sdft_pkg.
`default_nettype none

module sdft_mag import sdft_pkg::*; #(
   parameter int WINDOW_MAX = 4096,
   localparam int ACC_W = 31 + $clog2(WINDOW_MAX)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] re,
   input  logic signed [ACC_W-1:0] im,
   output logic                    done,
   output logic [MAG_W-1:0]        magnitude
);

   localparam int ABS_W  = ACC_W - 1;
   localparam int NCH    = (ABS_W + CH_W - 1) / CH_W;
   localparam int CI_W   = $clog2(NCH);
   localparam int PR_W   = ABS_W + CH_W;
   localparam int SQ_W   = 2 * ABS_W + 1;
   localparam int VW     = SQ_W - SQ_SHIFT;
   localparam int ROOT_W = (VW + 1) / 2;
   localparam int IT_W   = $clog2(ROOT_W + 1);
   localparam logic [63:0]   CAP_FULL = 64'(WINDOW_MAX) << 15;
   localparam logic [VW-1:0] CAP      = VW'((CAP_FULL > MAG_MAX) ? MAG_MAX : CAP_FULL);
   localparam logic [VW-1:0] BIT_INIT = VW'(1) << (2 * (ROOT_W - 1));

   typedef enum logic [1:0] {M_IDLE, M_SQ, M_ROOT, M_FIN} mag_state_type;

   mag_state_type state_ff, state_in;
   logic              done_ff, done_in;
   logic              more_ff, more_in;
   logic              pv_ff, pv_in;
   logic              sel_ff, sel_in;
   logic [CI_W-1:0]   c_ff, c_in;
   logic [CI_W-1:0]   sh_ff, sh_in;
   logic [ABS_W-1:0]  are_ff, are_in;
   logic [ABS_W-1:0]  aim_ff, aim_in;
   logic [PR_W-1:0]   prod_ff, prod_in;
   logic [SQ_W-1:0]   sum_ff, sum_in;
   logic [VW-1:0]     v_ff, v_in;
   logic [VW-1:0]     res_ff, res_in;
   logic [VW-1:0]     rbit_ff, rbit_in;
   logic [IT_W-1:0]   it_ff, it_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;

   logic [ABS_W-1:0]      op;
   logic [NCH*CH_W-1:0]   op_pad;
   logic [CH_W-1:0]       chunk;
   logic [VW-1:0]         trial;

   always_comb begin
      op     = sel_ff ? aim_ff : are_ff;
      op_pad = (NCH * CH_W)'(op);
      chunk  = op_pad[c_ff * CH_W +: CH_W];
      trial  = res_ff + rbit_ff;

      state_in = state_ff;
      done_in  = 1'b0;
      more_in  = more_ff;
      pv_in    = pv_ff;
      sel_in   = sel_ff;
      c_in     = c_ff;
      sh_in    = sh_ff;
      are_in   = are_ff;
      aim_in   = aim_ff;
      prod_in  = prod_ff;
      sum_in   = sum_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      rbit_in  = rbit_ff;
      it_in    = it_ff;
      mag_in   = mag_ff;

      case (state_ff)
         M_IDLE: begin
            if (start) begin
               are_in   = ABS_W'(re[ACC_W-1] ? -re : re);
               aim_in   = ABS_W'(im[ACC_W-1] ? -im : im);
               sum_in   = '0;
               more_in  = 1'b1;
               pv_in    = 1'b0;
               sel_in   = 1'b0;
               c_in     = '0;
               state_in = M_SQ;
            end
         end
         M_SQ: begin
            pv_in = more_ff;
            if (more_ff) begin
               prod_in = PR_W'(op) * PR_W'(chunk);
               sh_in   = c_ff;
               if (c_ff == CI_W'(NCH - 1)) begin
                  c_in = '0;
                  if (sel_ff) begin
                     more_in = 1'b0;
                  end else begin
                     sel_in = 1'b1;
                  end
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end
            if (pv_ff) begin
               sum_in = sum_ff + (SQ_W'(prod_ff) << (CH_W * sh_ff));
            end
            if (!more_ff && !pv_ff) begin
               v_in     = sum_ff[SQ_W-1:SQ_SHIFT];
               res_in   = '0;
               rbit_in  = BIT_INIT;
               it_in    = IT_W'(ROOT_W);
               state_in = M_ROOT;
            end
         end
         M_ROOT: begin
            if (v_ff >= trial) begin
               v_in   = v_ff - trial;
               res_in = (res_ff >> 1) + rbit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            rbit_in = rbit_ff >> 2;
            it_in   = it_ff - 1'b1;
            if (it_ff == IT_W'(1)) begin
               state_in = M_FIN;
            end
         end
         M_FIN: begin
            mag_in   = (res_ff > CAP) ? MAG_W'(CAP) : MAG_W'(res_ff);
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
         more_ff  <= 1'b0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         more_ff  <= more_in;
         pv_ff    <= pv_in;
         mag_ff   <= mag_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff  <= sel_in;
      c_ff    <= c_in;
      sh_ff   <= sh_in;
      are_ff  <= are_in;
      aim_ff  <= aim_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      v_ff    <= v_in;
      res_ff  <= res_in;
      rbit_ff <= rbit_in;
      it_ff   <= it_in;
   end

   assign done      = done_ff;
   assign magnitude = mag_ff;

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for sliding_window_dft_bin_magnitude: directed and random push/evaluate
// traffic, checked against an in-bench window model. Depends on sdft_pkg, sdft_if and the DUT.

module tb import sdft_pkg::*; ();

   localparam logic [63:0] MAG_CAP   = 64'd134217728;
   localparam int          IDLE_GAP  = 64;
   localparam int          RAND_EVAL = 35;

   logic clock;
   logic reset;

   sdft_req_if req_bus ();
   sdft_rsp_if rsp_bus ();
   sdft_csr_if csr_bus ();

   sliding_window_dft_bin_magnitude u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // window model
   int                 sine_q15 [4096];
   logic signed [15:0] samples [4096];
   logic [11:0]        write_ptr;
   logic [12:0]        window_len;

   logic [MAG_W-1:0]   expected_magnitudes [$];
   logic [MAG_W-1:0]   want;
   int                 send_idle_pct;
   int                 rsp_stall_pct;
   int                 n_push;
   int                 n_eval;
   int                 n_checked;
   int                 n_errors;

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic [63:0] q61_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = 128'(a) * 128'(b);
      return prod[124:61];
   endfunction

   function automatic int quarter_wave(input int unsigned k);
      logic [127:0] prod;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  acc;
      prod = 128'(PI_Q61) * 128'(k);
      x    = prod[74:11];
      x2   = q61_product(x, x);
      term = x;
      acc  = x;
      for (int n = 1; n <= 14; n++) begin
         term = q61_product(term, x2) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      acc = (acc + (64'd1 << 45)) >> 46;
      return (acc > 64'd32767) ? 32767 : int'(acc);
   endfunction

   function automatic void build_sine_q15();
      int q;
      for (int k = 0; k <= 1024; k++) begin
         q = (k == 0) ? 0 : (k == 1024) ? 32767 : quarter_wave(k);
         sine_q15[k % 4096]          = q;
         sine_q15[(2048 - k) % 4096] = q;
         sine_q15[(2048 + k) % 4096] = -q;
         sine_q15[(4096 - k) % 4096] = -q;
      end
   endfunction

   function automatic logic [MAG_W-1:0] predict_magnitude(input logic [31:0] step);
      longint       re_acc;
      longint       im_acc;
      longint       x;
      logic [127:0] re_abs;
      logic [127:0] im_abs;
      logic [127:0] energy;
      logic [63:0]  scaled;
      logic [63:0]  root;
      logic [63:0]  trial;
      logic [31:0]  ph;
      logic [11:0]  rd;
      logic [11:0]  si;
      int           n;
      re_acc = 0;
      im_acc = 0;
      ph     = '0;
      n      = (window_len > 13'd4096) ? 4096 : int'(window_len);
      rd     = write_ptr - 12'(n);
      for (int t = 0; t < n; t++) begin
         si     = ph[31:20];
         x      = samples[rd];
         re_acc += x * sine_q15[12'(si + 12'd1024)];
         im_acc += x * sine_q15[si];
         ph     = ph + step;
         rd     = rd + 12'd1;
      end
      re_abs = (re_acc < 0) ? 128'(-re_acc) : 128'(re_acc);
      im_abs = (im_acc < 0) ? 128'(-im_acc) : 128'(im_acc);
      energy = re_abs * re_abs + im_abs * im_abs;
      scaled = 64'(energy >> SQ_SHIFT);
      root   = '0;
      for (int b = 28; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= scaled) begin
            root = trial;
         end
      end
      if (root > MAG_CAP) begin
         root = MAG_CAP;
      end
      return MAG_W'(root);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_magnitudes.size() == 0) begin
            $display("%0t: magnitude %0d with no evaluate pending", $time,
                     rsp_bus.magnitude);
            n_errors++;
         end else begin
            want = expected_magnitudes.pop_front();
            if (rsp_bus.magnitude !== want) begin
               $display("%0t: magnitude mismatch, expected %0d, got %0d", $time, want,
                        rsp_bus.magnitude);
               n_errors++;
            end
            n_checked++;
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic cmd, input logic [15:0] smp, input logic [31:0] step);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.sample     <= smp;
      req_bus.phase_step <= step;
      do @(posedge clock); while (!req_bus.ready);
      if (cmd == CMD_PUSH) begin
         samples[write_ptr] = smp;
         write_ptr          = write_ptr + 12'd1;
         n_push++;
      end else begin
         expected_magnitudes.insert(expected_magnitudes.size(), predict_magnitude(step));
         n_eval++;
      end
      @(negedge clock);
   endtask

   task automatic wait_for_idle();
      req_bus.valid <= 1'b0;
      while (expected_magnitudes.size() != 0) @(negedge clock);
      repeat (IDLE_GAP) @(negedge clock);
   endtask

   task automatic write_window(input logic [12:0] len);
      wait_for_idle();
      csr_bus.valid         <= 1'b1;
      csr_bus.window_length <= len;
      do @(posedge clock); while (!csr_bus.ready);
      window_len = len;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic test_reset_state();
      send_item(CMD_EVAL, 16'h1234, 32'h0123_4567);
      send_item(CMD_PUSH, 16'h7FFF, 32'hFFFF_FFFF);
      send_item(CMD_EVAL, 16'h8000, 32'h0000_0000);
   endtask

   task automatic test_sample_extremes();
      write_window(13'd8);
      repeat (8) send_item(CMD_PUSH, 16'h8000, $urandom);
      send_item(CMD_EVAL, 16'($urandom), 32'h0000_0000);
      send_item(CMD_EVAL, 16'($urandom), 32'h8000_0000);
      send_item(CMD_EVAL, 16'($urandom), 32'h4000_0000);
      send_item(CMD_EVAL, 16'($urandom), 32'hFFFF_FFFF);
      write_window(13'd4);
      repeat (2) begin
         send_item(CMD_PUSH, 16'h7FFF, 32'h0);
         send_item(CMD_PUSH, 16'h8000, 32'h0);
      end
      send_item(CMD_EVAL, 16'h0, 32'h8000_0000);
   endtask

   task automatic test_window_limits();
      write_window(13'd0);
      send_item(CMD_EVAL, 16'h0, 32'h1000_0000);
      write_window(13'd1);
      send_item(CMD_EVAL, 16'h0, 32'h1000_0000);
      write_window(13'd8191);
      send_item(CMD_EVAL, 16'h0, 32'h0010_0000);
      write_window(13'd4096);
      send_item(CMD_EVAL, 16'h0, 32'h0010_0000);
   endtask

   task automatic run_random(input int items, input logic [12:0] len, input int send_pct,
                             input int stall_pct);
      logic        cmd;
      logic [15:0] smp;
      logic [31:0] step;
      int          pick;
      write_window(len);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (items) begin
         cmd  = ($urandom_range(99) < RAND_EVAL) ? CMD_EVAL : CMD_PUSH;
         pick = $urandom_range(9);
         smp  = (pick < 7) ? 16'($urandom) :
                (pick < 8) ? 16'h8000 :
                (pick < 9) ? 16'h7FFF : 16'($urandom_range(0, 15)) - 16'd8;
         pick = $urandom_range(9);
         step = (pick < 5) ? $urandom :
                (pick < 8) ? 32'($urandom_range(0, len)) * (32'hFFFF_FFFF / 32'(len)) :
                32'($urandom_range(0, 3));
         send_item(cmd, smp, step);
      end
   endtask

   task automatic test_random_traffic();
      run_random(34, 13'd33, 0, 0);
      run_random(30, 13'd1, 53, 0);
      run_random(30, 13'd200, 0, 53);
      run_random(12, 13'd4096, 27, 27);
      run_random(10, 13'd2, 27, 27);
   endtask

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.command       = CMD_PUSH;
      req_bus.sample        = '0;
      req_bus.phase_step    = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.window_length = WLEN_RESET;
      send_idle_pct         = 0;
      rsp_stall_pct         = 0;
      n_push                = 0;
      n_eval                = 0;
      n_checked             = 0;
      n_errors              = 0;
      write_ptr             = '0;
      window_len            = 13'd4096;
      foreach (samples[i]) samples[i] = '0;
      build_sine_q15();

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_sample_extremes();
      test_window_limits();
      test_random_traffic();

      wait_for_idle();
      $display("ran %0d pushes and %0d evaluates, %0d magnitudes checked", n_push, n_eval,
               n_checked);
      $display("windows 0 to 8191, sample and phase extremes, with and without idling");
      if (n_errors == 0) begin
         $display("[sliding_window_dft_bin_magnitude] OK");
      end else begin
         $display("[sliding_window_dft_bin_magnitude] ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout at %0t", $time);
      $display("[sliding_window_dft_bin_magnitude] ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/sdft_pkg.sv
rtl/sdft_if.sv
rtl/sdft_ram.sv
rtl/sdft_sine_rom.sv
rtl/sdft_mag.sv
rtl/sliding_window_dft_bin_magnitude.sv
tb/sv/tb.sv
